// ===== rtl/core/dqsr_pkg.sv =====
// Shared types, sizes and slot arithmetic for the deque with search and reverse.
// Used by dqsr_ctrl and the top level deque_with_search_and_reverse.
package dqsr_pkg;

    // Sizing of the ring store
    localparam int DEPTH   = 16;
    localparam int ID_BITS = 16;
    localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 4;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Port field widths
    localparam int CMD_W      = 3;
    localparam int ID_PORT_W  = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(DEPTH);
    localparam logic [SLOT_W+1:0] DEPTH_S    = (SLOT_W + 2)'(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_SEARCH     = 3'd3,
        CMD_UPDATE     = 3'd4,
        CMD_REVERSE    = 3'd5,
        CMD_COUNT      = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_BAD_POS   = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    // One command as taken from the input channel
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_BITS-1:0] id;
        logic [POS_W-1:0]   pos;
    } item_t;

    // One finished result
    typedef struct packed {
        status_t            status;
        logic [ID_BITS-1:0] rid;
        logic [CNT_W-1:0]   count;
    } res_t;

    // Access to the slot store
    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  waddr;
        logic [ID_BITS-1:0] wdata;
        logic [SLOT_W-1:0]  raddr;
    } ram_req_t;

    // Ring slot that lies a number of steps from base, walking down when rev is set
    function automatic logic [SLOT_W-1:0] slot_calc(
        input logic [SLOT_W-1:0] base,
        input logic [CNT_W-1:0]  steps,
        input logic              rev
    );
        logic [SLOT_W+1:0] d;
        logic [SLOT_W+1:0] s;
        d = (SLOT_W + 2)'(steps);
        if (d >= DEPTH_S) begin
            d = d - DEPTH_S;
        end
        if (rev) begin
            s = (SLOT_W + 2)'(base) + DEPTH_S - d;
        end else begin
            s = (SLOT_W + 2)'(base) + d;
        end
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/dqsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module dqsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dqsr_ctrl.sv =====
// Command sequencer: holds front slot, count and direction, drives the slot store.
// Depends on dqsr_pkg; reads the store through a RAM with registered read data.
module dqsr_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  dqsr_pkg::item_t            item,
    output logic                       res_valid,
    input  logic                       res_ready,
    output dqsr_pkg::res_t             res,
    output dqsr_pkg::ram_req_t         ram_req,
    input  logic [dqsr_pkg::ID_BITS-1:0] ram_rdata
);
    import dqsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [SLOT_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rev_reg, rev_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    status_t            status_reg, status_next;
    logic [ID_BITS-1:0] rid_reg, rid_next;

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.rid    = rid_reg;
    assign res.count  = count_reg;

    // Next-state and store access for each command
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        rev_next      = rev_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        status_next   = status_reg;
        rid_next      = rid_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = front_reg;
        ram_req.wdata = item_reg.id;
        ram_req.raddr = front_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                status_next = STAT_OK;
                rid_next    = '0;
                state_next  = S_DONE;
                case (cmd_t'(item_reg.cmd))
                    CMD_PUSH_FRONT: begin
                        if (count_reg == COUNT_FULL) begin
                            status_next = STAT_FULL;
                        end else begin
                            front_next    = slot_calc(front_reg, CNT_W'(1), !rev_reg);
                            ram_req.we    = 1'b1;
                            ram_req.waddr = front_next;
                            count_next    = count_reg + 1'b1;
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (count_reg == COUNT_FULL) begin
                            status_next = STAT_FULL;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = slot_calc(front_reg, count_reg, rev_reg);
                            count_next    = count_reg + 1'b1;
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (count_reg == '0) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            // Read the old front, then advance past it
                            ram_req.raddr = front_reg;
                            front_next    = slot_calc(front_reg, CNT_W'(1), rev_reg);
                            count_next    = count_reg - 1'b1;
                            state_next    = S_POP_RD;
                        end
                    end
                    CMD_SEARCH: begin
                        status_next = STAT_NOT_FOUND;
                        idx_next    = '0;
                        pend_next   = 1'b0;
                        state_next  = S_SCAN;
                    end
                    CMD_UPDATE: begin
                        if (CMP_W'(item_reg.pos) >= CMP_W'(count_reg)) begin
                            status_next = STAT_BAD_POS;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = slot_calc(front_reg, CNT_W'(item_reg.pos),
                                                      rev_reg);
                        end
                    end
                    CMD_REVERSE: begin
                        if (count_reg != '0) begin
                            front_next = slot_calc(front_reg, count_reg - 1'b1, rev_reg);
                        end
                        rev_next = !rev_reg;
                    end
                    default: begin
                        // Count and the unused code change nothing
                    end
                endcase
            end

            S_POP_RD: begin
                rid_next   = ram_rdata;
                state_next = S_DONE;
            end

            S_SCAN: begin
                // Issue one read per cycle, compare the data of the previous read
                ram_req.raddr = slot_calc(front_reg, idx_reg, rev_reg);
                if (idx_reg < count_reg) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && (ram_rdata == item_reg.id)) begin
                    status_next = STAT_OK;
                    rid_next    = item_reg.id;
                    state_next  = S_DONE;
                end else if (!pend_reg && (idx_reg == count_reg)) begin
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, pointers and the registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            pend_reg  <= pend_next;
        end
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
    end

endmodule

// ===== rtl/core/deque_with_search_and_reverse.sv =====
// Bounded double-ended ID queue with search, positional update and reverse.
// Each command passes from an execute state to a done state; pop adds a read state
// between them, and search a scan state that reads one slot-store entry per cycle.
// One command at a time; the next is taken once the result is handed to the
// output register.
// Reset (aresetn low, synchronous): queue empty, normal order, no result pending.
module deque_with_search_and_reverse (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: cmd[2:0], entry_id[18:3], position[22:19], zero[23]
    input  logic [dqsr_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: status[2:0], result_id[18:3], entry_count[23:19]
    output logic [dqsr_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import dqsr_pkg::*;

    item_t                 item;
    res_t                  res;
    ram_req_t              ram_req;
    logic [ID_BITS-1:0]    ram_rdata;
    logic                  res_valid;
    logic                  res_ready;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Unpack the input transaction
    assign item.cmd = s_tdata[CMD_W-1:0];
    assign item.id  = ID_BITS'(s_tdata[CMD_W +: ID_PORT_W]);
    assign item.pos = s_tdata[CMD_W+ID_PORT_W +: POS_W];

    dqsr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    dqsr_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Output register: load a new result when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            out_data_next  = {COUNT_W'(res.count), ID_PORT_W'(res.rid),
                              STATUS_W'(res.status)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
